// ===== src/bswc_pkg.sv =====
`default_nettype none

package bswc_pkg;

    // Largest frame the counters and accumulators are sized for.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int DIFF_W = 8;
    localparam int THR_W  = 8;
    localparam int SIZE_W = 13;
    localparam int CENT_W = 13;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 13;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int MUL_W = POS_W + DIFF_W;

    // Pixel count of the largest frame, plus one bit of headroom.
    localparam int CNT_BITS = COL_W + ROW_W + 1;
    localparam int WGT_W    = DIFF_W + CNT_BITS;
    localparam int SUM_W    = POS_W + DIFF_W + CNT_BITS;

    // The mean of a position never exceeds the largest position.
    localparam int DIV_BITS = POS_W;
    localparam int DVS_W    = WGT_W + DIV_BITS - 1;
    localparam int CMP_W    = (SUM_W > DVS_W) ? SUM_W : DVS_W;
    localparam int DCNT_W   = $clog2(DIV_BITS + 1);

    localparam int SCMP_W = ((POS_W > SIZE_W) ? POS_W : SIZE_W) + 1;

    localparam logic [IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [THR_W-1:0]  THRESHOLD_RST    = 8'd50;
    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [CENT_W-1:0] CENT_NONE        = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_COL,
        ST_ACC_ROW,
        ST_DECIDE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

    // A size of zero acts as one; a size above the maximum acts as the maximum.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int maxv);
        logic [SIZE_W:0] vx;
        vx = {1'b0, v};
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (int'(vx) > maxv) begin
            return SIZE_W'(maxv);
        end else begin
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/bswc_div.sv =====
`default_nettype none

module bswc_div (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           start,
    input  wire [bswc_pkg::SUM_W-1:0]     numer,
    input  wire [bswc_pkg::WGT_W-1:0]     denom,
    output bswc_pkg::div_stat_t           stat,
    output logic [bswc_pkg::DIV_BITS-1:0] quot
);
    import bswc_pkg::*;

    // Restoring division, one quotient bit per cycle, MSB first.
    logic [SUM_W-1:0]    rem_reg;
    logic [DVS_W-1:0]    dvs_reg;
    logic [DIV_BITS-1:0] q_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic                fits;
    logic [CMP_W-1:0]    diff_next;

    assign fits      = CMP_W'(rem_reg) >= CMP_W'(dvs_reg);
    assign diff_next = CMP_W'(rem_reg) - CMP_W'(dvs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0) && !start;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= numer;
            dvs_reg <= {denom, {(DIV_BITS-1){1'b0}}};
            q_reg   <= '0;
            cnt_reg <= DCNT_W'(DIV_BITS - 1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= SUM_W'(diff_next);
            end
            q_reg   <= {q_reg[DIV_BITS-2:0], fits};
            dvs_reg <= dvs_reg >> 1;
            cnt_reg <= cnt_reg - DCNT_W'(1);
        end
    end

    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

`default_nettype wire

// ===== src/background_subtract_weighted_centroid.sv =====
`default_nettype none

// A pixel's result reaches the output register through the decide and finish states,
// after the column and row accumulation states when it counts toward the centroid;
// the next input transfer waits until it is loaded. A frame end with any weight adds
// two 12-bit divisions on the shared divider. A result not yet taken stalls the input.
// A synchronous active-low reset restores the register defaults (threshold
// 50, 640 by 480) and clears the counters, accumulators and output valid.
module background_subtract_weighted_centroid (
    input  wire         aclk,
    input  wire         aresetn,

    // Fields from bit 0 up: pixel [7:0], background_pixel [15:8].
    input  wire  [15:0] s_tdata,
    input  wire         s_tvalid,
    output logic        s_tready,

    // Fields from bit 0 up: diff_pixel [7:0], centroid_x [20:8],
    // centroid_y [33:21], zero fill [39:34].
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,

    input  wire                        cfg_wr_en,
    input  wire  [bswc_pkg::IDX_W-1:0] cfg_index,
    input  wire  [bswc_pkg::CFG_W-1:0] cfg_wdata
);
    import bswc_pkg::*;

    // Configuration registers.
    logic [THR_W-1:0]  threshold_reg;
    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;

    // Sequencer and frame state.
    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SUM_W-1:0]  sum_x_reg;
    logic [SUM_W-1:0]  sum_y_reg;
    logic [WGT_W-1:0]  wgt_reg;

    // The pixel under work.
    logic [DIFF_W-1:0] diff_reg;
    logic [DIFF_W-1:0] clip_reg;
    logic [CENT_W-1:0] cx_reg;
    logic [CENT_W-1:0] cy_reg;

    // Result register.
    logic [DIFF_W-1:0] m_diff_reg;
    logic              m_last_reg;
    logic [CENT_W-1:0] m_cx_reg;
    logic [CENT_W-1:0] m_cy_reg;
    logic              m_valid_reg;

    // Input difference and threshold test.
    logic [PIX_W-1:0]  in_pixel;
    logic [PIX_W-1:0]  in_bg;
    logic signed [PIX_W:0] in_diff;
    logic              in_hit;
    logic              in_take;

    assign in_pixel = s_tdata[7:0];
    assign in_bg    = s_tdata[15:8];
    assign in_diff  = $signed({1'b0, in_pixel}) - $signed({1'b0, in_bg});
    assign in_hit   = in_diff >= $signed({1'b0, threshold_reg});
    assign in_take  = s_tvalid && s_tready;

    // Frame position tests against the clamped size.
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic              last_col;
    logic              frame_end;

    assign w_eff     = clamp_size(frame_width_reg, MAX_WIDTH);
    assign h_eff     = clamp_size(frame_height_reg, MAX_HEIGHT);
    assign last_col  = SCMP_W'(col_reg) >= SCMP_W'(w_eff) - SCMP_W'(1);
    assign frame_end = last_col && (SCMP_W'(row_reg) >= SCMP_W'(h_eff) - SCMP_W'(1));

    // The one multiplier serves the column product and then the row product.
    logic [POS_W-1:0] mul_a;
    logic [MUL_W-1:0] product;

    assign mul_a   = (state_reg == ST_ACC_COL) ? POS_W'(col_reg) : POS_W'(row_reg);
    assign product = MUL_W'(mul_a) * MUL_W'(diff_reg);

    // Shared divider.
    logic                div_start;
    logic [SUM_W-1:0]    div_numer;
    div_stat_t           div_stat;
    logic [DIV_BITS-1:0] div_quot;

    bswc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (wgt_reg),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // Control decoded from the state.
    logic out_free;
    logic out_load;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    state_next = in_hit ? ST_ACC_COL : ST_DECIDE;
                end
            end
            ST_ACC_COL: begin
                state_next = ST_ACC_ROW;
            end
            ST_ACC_ROW: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (frame_end && wgt_reg != '0) begin
                    state_next = ST_DIV_X;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV_X: begin
                if (div_stat.done) begin
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_stat.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        div_numer = sum_x_reg;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_DECIDE: begin
                div_start = frame_end && (wgt_reg != '0);
            end
            ST_DIV_X: begin
                // The column quotient lands as the row division starts.
                div_start = div_stat.done;
                div_numer = sum_y_reg;
            end
            ST_FINISH: begin
                out_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESHOLD_RST;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= cfg_wdata[THR_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pixel capture and the centroid quotients.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            diff_reg <= in_diff[DIFF_W-1:0];
            clip_reg <= in_diff[PIX_W] ? '0 : in_diff[DIFF_W-1:0];
        end
        if (state_reg == ST_DECIDE) begin
            cx_reg <= CENT_NONE;
            cy_reg <= CENT_NONE;
        end else if (state_reg == ST_DIV_X && div_stat.done) begin
            cx_reg <= CENT_W'(div_quot);
        end else if (state_reg == ST_DIV_Y && div_stat.done) begin
            cy_reg <= CENT_W'(div_quot);
        end
    end

    // Accumulators and the raster position. The frame is cleared as its
    // last result is loaded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            wgt_reg   <= '0;
        end else if (state_reg == ST_ACC_COL) begin
            sum_x_reg <= sum_x_reg + SUM_W'(product);
        end else if (state_reg == ST_ACC_ROW) begin
            sum_y_reg <= sum_y_reg + SUM_W'(product);
            wgt_reg   <= wgt_reg + WGT_W'(diff_reg);
        end else if (out_load) begin
            if (frame_end) begin
                col_reg   <= '0;
                row_reg   <= '0;
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                wgt_reg   <= '0;
            end else if (last_col) begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Output register: it holds a result until the downstream transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_diff_reg <= clip_reg;
            m_last_reg <= frame_end;
            m_cx_reg   <= frame_end ? cx_reg : '0;
            m_cy_reg   <= frame_end ? cy_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_cy_reg, m_cx_reg, m_diff_reg};

endmodule

`default_nettype wire

// ===== dv/background_subtract_weighted_centroid_tb.sv =====
`timescale 1ns / 100ps

module background_subtract_weighted_centroid_tb;

    import bswc_pkg::*;

    // The block decodes three register indexes; the fourth must be ignored.
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    // The run is stopped here whatever happens. The slowest legal run is
    // well under a fifth of this: about 1500 transfers, each at worst the
    // longest sender gap and receiver stall, the block's own work and a
    // frame-end division, plus two long receiver hold-offs.
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_PIXELS  = 1450;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 60;

    // Pixel styles for the random phases.
    localparam int STYLE_SPOT    = 0;
    localparam int STYLE_UNIFORM = 1;
    localparam int STYLE_DARK    = 2;

    // One expected output transfer.
    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic              done;
        logic [CENT_W-1:0] cx;
        logic [CENT_W-1:0] cy;
    } px_result_t;

    // Tracks the raster position and the three weighted sums the same way
    // the block should, and keeps the outputs that are still owed.
    class centroid_checker;
        logic [THR_W-1:0]  thr;
        logic [SIZE_W-1:0] fw;
        logic [SIZE_W-1:0] fh;
        int unsigned       col;
        int unsigned       row;
        longint unsigned   col_sum;
        longint unsigned   row_sum;
        longint unsigned   weight;
        px_result_t        expected_px[$];
        int                errors;

        function new();
            thr     = THRESHOLD_RST;
            fw      = FRAME_WIDTH_RST;
            fh      = FRAME_HEIGHT_RST;
            col     = 0;
            row     = 0;
            col_sum = 0;
            row_sum = 0;
            weight  = 0;
            errors  = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_THRESHOLD:    thr = val[THR_W-1:0];
                REG_FRAME_WIDTH:  fw = val[SIZE_W-1:0];
                REG_FRAME_HEIGHT: fh = val[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_px.size();
        endfunction

        // Called for every accepted input transfer.
        function void log_pixel(logic [PIX_W-1:0] pix, logic [PIX_W-1:0] bg);
            int              d;
            longint unsigned du;
            int unsigned     w;
            int unsigned     h;
            longint unsigned qx;
            longint unsigned qy;
            bit              last_col;
            px_result_t      r;
            d = int'(pix) - int'(bg);
            r = '0;
            r.diff = (d > 0) ? d[DIFF_W-1:0] : '0;
            if (d >= int'(thr)) begin
                du = longint'(d);
                col_sum += longint'(col) * du;
                row_sum += longint'(row) * du;
                weight  += du;
            end
            w = (fw == 0) ? 1 : ((fw > MAX_WIDTH) ? MAX_WIDTH : fw);
            h = (fh == 0) ? 1 : ((fh > MAX_HEIGHT) ? MAX_HEIGHT : fh);
            // Comparing "at or past" lets a shrunken size close a row or frame.
            last_col = (col >= w - 1);
            if (last_col && row >= h - 1) begin
                if (weight > 0) begin
                    qx = col_sum / weight;
                    qy = row_sum / weight;
                    r.cx = qx[CENT_W-1:0];
                    r.cy = qy[CENT_W-1:0];
                end else begin
                    r.cx = CENT_NONE;
                    r.cy = CENT_NONE;
                end
                r.done  = 1'b1;
                col     = 0;
                row     = 0;
                col_sum = 0;
                row_sum = 0;
                weight  = 0;
            end else if (last_col) begin
                col = 0;
                row++;
            end else begin
                col++;
            end
            expected_px = {expected_px, r};
        endfunction

        // Called for every accepted output transfer.
        function void check_px(logic [39:0] data, logic last);
            px_result_t e;
            if (expected_px.size() == 0) begin
                $error("output transfer with no pixel outstanding: tdata %h", data);
                errors++;
                return;
            end
            e = expected_px.pop_front();
            if (data[7:0] !== e.diff) begin
                $error("diff_pixel: expected %0d, got %0d", e.diff, data[7:0]);
                errors++;
            end
            if (last !== e.done) begin
                $error("frame_done: expected %0d, got %0d", e.done, last);
                errors++;
            end
            if (data[20:8] !== e.cx) begin
                $error("centroid_x: expected %0d, got %0d",
                       $signed(e.cx), $signed(data[20:8]));
                errors++;
            end
            if (data[33:21] !== e.cy) begin
                $error("centroid_y: expected %0d, got %0d",
                       $signed(e.cy), $signed(data[33:21]));
                errors++;
            end
        endfunction

        function void leftover();
            if (expected_px.size() != 0) begin
                $error("%0d output transfers never arrived", expected_px.size());
                errors++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic [15:0]       s_tdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       m_tdata;
    logic              m_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic              cfg_wr_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;

    centroid_checker   chk;
    int                pixels_sent;
    int                cycle_count;
    bit                no_gaps;    // Both sides stop idling while this is set.
    bit                hold_req;   // Asks the receiver for one long hold-off.

    background_subtract_weighted_centroid dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("background_subtract_weighted_centroid verification failed");
            $finish;
        end
    end

    // Offers one pixel after a random gap and waits for the transfer. The
    // valid stays high across back-to-back transfers, so it only ever gets
    // one assignment per falling edge.
    task automatic send_pixel(input logic [15:0] word);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chk.log_pixel(word[7:0], word[15:8]);
        pixels_sent++;
    endtask

    // Stops offering and waits until every owed output transfer has come.
    // Each item always produces an output, so the block is idle afterwards.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (chk.pending() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        chk.write_reg(idx, val);
    endtask

    // Mostly small frames so that many of them complete; now and then a
    // zero or an oversized value, which the block must clamp. Large sizes
    // only leave a frame open until a later phase shrinks it.
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return '0;
            1:       return SIZE_W'(MAX_WIDTH);
            2:       return '1;
            3:       return SIZE_W'(MAX_WIDTH + 1);
            4, 5, 6: return SIZE_W'($urandom_range(1, 2));
            default: return SIZE_W'($urandom_range(3, 12));
        endcase
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 5);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return THRESHOLD_RST;
            default: return THR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Returns {background, pixel}. The spot style mixes bright spots on a
    // dark background, differences right at the threshold, and negative
    // differences; the dark style never reaches a positive difference.
    function automatic logic [15:0] pick_pixel(input int style);
        int p;
        int b;
        int r;
        if (style == STYLE_UNIFORM) begin
            p = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
        end else if (style == STYLE_DARK) begin
            b = $urandom_range(0, 255);
            p = $urandom_range(0, b);
        end else begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
                b = $urandom_range(0, 40);
                p = $urandom_range(150, 255);
            end else if (r < 5) begin
                b = $urandom_range(0, 255);
                p = b + int'(chk.thr) + int'($urandom_range(0, 2)) - 1;
                if (p > 255) p = 255;
                if (p < 0) p = 0;
            end else begin
                p = $urandom_range(0, 80);
                b = $urandom_range(40, 255);
            end
        end
        return {b[7:0], p[7:0]};
    endfunction

    // Receiver: a random stall before each output transfer, none while
    // no_gaps is set, and a long counted hold-off whenever one is asked for.
    initial begin
        int gap;
        int n;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
                hold_req = 1'b0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            chk.check_px(m_tdata, m_tlast);
        end
    end

    // Main sequence: reset, a directed part, then random phases with a
    // fresh register setting between them.
    initial begin
        int                phase;
        int                len;
        int                style;
        int                i;
        logic [CFG_W-1:0]  v;
        chk         = new();
        pixels_sent = 0;
        no_gaps     = 1'b0;
        hold_req    = 1'b0;
        aresetn     = 1'b0;
        s_tdata     = '0;
        s_tvalid    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Two pixels at the reset setting: largest difference and a fully
        // negative one that must clamp to zero.
        send_pixel({8'd0, 8'd255});
        send_pixel({8'd255, 8'd0});
        drain();

        // A 3 by 2 frame. The open row already reaches the new width's last column, so the
        // first pixel closes it at once. The threshold value carries junk in
        // its upper bits that the block must drop.
        cfg_write(REG_FRAME_WIDTH, 13'd3);
        cfg_write(REG_FRAME_HEIGHT, 13'd2);
        cfg_write(REG_THRESHOLD, {5'h1F, THRESHOLD_RST});
        send_pixel({8'd0, 8'd50});      // difference exactly at the threshold
        send_pixel({8'd0, 8'd49});      // one below it
        send_pixel({8'd0, 8'd255});
        send_pixel({8'd0, 8'd0});
        send_pixel({8'd255, 8'd255});
        send_pixel({8'd20, 8'd180});
        drain();

        // Zero threshold with no positive difference: zero differences count
        // but add no weight, so each frame reports no centroid.
        cfg_write(REG_THRESHOLD, 13'h100);
        cfg_write(REG_UNUSED, '1);
        send_pixel({8'd7, 8'd7});
        send_pixel({8'd0, 8'd0});
        send_pixel({8'd200, 8'd100});
        send_pixel({8'd255, 8'd255});
        send_pixel({8'd1, 8'd0});
        send_pixel({8'd9, 8'd9});
        drain();

        // Width zero acts as one and an oversized height as the maximum;
        // then a zero height ends the frame on the very next pixel.
        cfg_write(REG_FRAME_WIDTH, '0);
        cfg_write(REG_FRAME_HEIGHT, '1);
        send_pixel({8'd10, 8'd200});
        send_pixel({8'd0, 8'd255});
        drain();
        cfg_write(REG_FRAME_HEIGHT, '0);
        send_pixel({8'd30, 8'd90});
        send_pixel({8'd90, 8'd30});

        phase = 0;
        while (pixels_sent < RANDOM_PIXELS + 18) begin
            // Every phase boundary is also a full pause of the sender.
            drain();
            no_gaps = 1'b0;
            if ($urandom_range(0, 3) != 0) begin
                v = {5'($urandom_range(0, 31)), pick_threshold()};
                cfg_write(REG_THRESHOLD, v);
            end
            if ($urandom_range(0, 3) != 0) cfg_write(REG_FRAME_WIDTH, pick_size());
            if ($urandom_range(0, 3) != 0) cfg_write(REG_FRAME_HEIGHT, pick_size());
            if ($urandom_range(0, 9) == 0) cfg_write(REG_UNUSED, CFG_W'($urandom));
            i = $urandom_range(0, 5);
            style = (i < 3) ? STYLE_SPOT : ((i < 5) ? STYLE_UNIFORM : STYLE_DARK);
            len = $urandom_range(40, 160);
            no_gaps = ($urandom_range(0, 3) == 0);
            // Twice in the run the receiver holds off while the sender keeps
            // pushing, which fills the block and stalls its input.
            if (phase == 2 || phase == 7) begin
                hold_req = 1'b1;
                no_gaps  = 1'b1;
                len      = 200;
            end
            // The last phase stops at the planned item count.
            if (len > RANDOM_PIXELS + 18 - pixels_sent) begin
                len = RANDOM_PIXELS + 18 - pixels_sent;
            end
            for (i = 0; i < len; i++) send_pixel(pick_pixel(style));
            phase++;
        end

        drain();
        no_gaps = 1'b0;
        // A spurious extra output transfer would still be caught here.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        chk.leftover();
        if (chk.errors == 0) begin
            $display("background_subtract_weighted_centroid verification clean");
        end else begin
            $display("background_subtract_weighted_centroid verification failed");
        end
        $finish;
    end

endmodule

// ===== background_subtract_weighted_centroid.f =====
src/bswc_pkg.sv
src/bswc_div.sv
src/background_subtract_weighted_centroid.sv
dv/background_subtract_weighted_centroid_tb.sv
